@@ design/sse_pkg.sv @@
// ----------------------------------------------------------------------------
// sse_pkg: shared types and constants of the silhouette edge extruder
// Holds request, result, configuration, vertex and probe types and the codes.
// ----------------------------------------------------------------------------
package sse_pkg;

  // operation codes of a request
  localparam logic [1:0] OpLoad    = 2'd0;
  localparam logic [1:0] OpProcess = 2'd1;
  localparam logic [1:0] OpClear   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] RegDirX   = 2'd0;
  localparam logic [1:0] RegDirY   = 2'd1;
  localparam logic [1:0] RegDirZ   = 2'd2;
  localparam logic [1:0] RegMinLen = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        extrude_length;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_t;

  // one stored vertex position
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vtx_t;

  // a directed edge being searched, carried down the cell row
  typedef struct packed {
    logic valid;
    logic found;
    vtx_t from_v;
    vtx_t to_v;
  } probe_t;

endpackage

@@ design/shadow_silhouette_edge_extruder_top.sv @@
// ----------------------------------------------------------------------------
// shadow_silhouette_edge_extruder_top: silhouette extrusion for shadow volumes
// Stores triangles, finds silhouette edges and emits extruded quads.
//
//  channel  signals                   direction  handshake
//  request  start_i, busy_o, req_i    in         start_i & !busy_o
//  config   cfg_valid_i/ready_o/cfg_i in         valid & ready
//  result   res_valid_o, res_o        out        strobe, one cycle
//
// A load, a clear or a process with no triangle left keeps the block idle. A
// process runs a fetch, then a scan while a row of three search cells checks
// the edges of every complete stored triangle, then a drain. Each emitted
// edge issues six vertices; each result leaves the extrusion pipeline in the
// cycle after its vertex is issued, and a wait state follows the last
// vertex. Reset clears the counters and state and presets the configuration;
// the store holds undefined data until loaded. Results cannot be stalled.
// ----------------------------------------------------------------------------
module shadow_silhouette_edge_extruder_top #(
  parameter int MAX_TRIANGLES = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  sse_pkg::req_t   req_i,
  output logic            busy_o,
  input  logic            cfg_valid_i,
  input  sse_pkg::cfg_t   cfg_i,
  output logic            cfg_ready_o,
  output logic            res_valid_o,
  output sse_pkg::res_t   res_o
);

  localparam int Depth = 3 * MAX_TRIANGLES;
  localparam int AW    = $clog2(Depth + 1);
  localparam int TW    = $clog2(MAX_TRIANGLES + 1);
  localparam int RW    = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StFetch = 6'b000010,
    StScan  = 6'b000100,
    StDrain = 6'b001000,
    StEmit  = 6'b010000,
    StWait  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] dir_x_q, dir_y_q, dir_z_q;
  logic [31:0] min_len_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_x_q   <= 16'd0;
      dir_y_q   <= 16'hc000;
      dir_z_q   <= 16'd0;
      min_len_q <= 32'd655;
    end else if (cfg_valid_i) begin
      unique case (cfg_i.index)
        sse_pkg::RegDirX:   dir_x_q   <= cfg_i.data[15:0];
        sse_pkg::RegDirY:   dir_y_q   <= cfg_i.data[15:0];
        sse_pkg::RegDirZ:   dir_z_q   <= cfg_i.data[15:0];
        sse_pkg::RegMinLen: min_len_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // vertex memory, three words a row so a triangle reads from one address
  sse_pkg::vtx_t mem_p0 [MAX_TRIANGLES];
  sse_pkg::vtx_t mem_p1 [MAX_TRIANGLES];
  sse_pkg::vtx_t mem_p2 [MAX_TRIANGLES];
  logic [31:0]   mem_l0 [MAX_TRIANGLES];
  logic [31:0]   mem_l1 [MAX_TRIANGLES];
  logic [31:0]   mem_l2 [MAX_TRIANGLES];

  logic [AW-1:0] count_q;
  logic [TW-1:0] row_q;
  logic [1:0]    col_q;
  logic [TW-1:0] next_q;
  logic [TW-1:0] tris;
  logic          accept;
  logic [TW-1:0] wrow;
  logic [1:0]    wcol;

  // complete triangles and the slot of the next load
  assign accept = start_i && !busy_o;
  assign tris   = row_q;
  assign wrow   = row_q;
  assign wcol   = col_q;

  sse_pkg::vtx_t wv;
  assign wv = '{x: req_i.pos_x, y: req_i.pos_y, z: req_i.pos_z};

  logic do_load;
  assign do_load = accept && req_i.operation == sse_pkg::OpLoad
                   && count_q < AW'(Depth);

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      case (wcol)
        2'd0: begin
          mem_p0[wrow[RW-1:0]] <= wv;
          mem_l0[wrow[RW-1:0]] <= req_i.extrude_length;
        end
        2'd1: begin
          mem_p1[wrow[RW-1:0]] <= wv;
          mem_l1[wrow[RW-1:0]] <= req_i.extrude_length;
        end
        default: begin
          mem_p2[wrow[RW-1:0]] <= wv;
          mem_l2[wrow[RW-1:0]] <= req_i.extrude_length;
        end
      endcase
    end
  end

  // read port
  logic [TW-1:0] raddr_d;
  sse_pkg::vtx_t r0_q, r1_q, r2_q;
  logic [31:0]   rl0_q, rl1_q, rl2_q;
  always_ff @(posedge clk_i) begin
    r0_q  <= mem_p0[raddr_d[RW-1:0]];
    r1_q  <= mem_p1[raddr_d[RW-1:0]];
    r2_q  <= mem_p2[raddr_d[RW-1:0]];
    rl0_q <= mem_l0[raddr_d[RW-1:0]];
    rl1_q <= mem_l1[raddr_d[RW-1:0]];
    rl2_q <= mem_l2[raddr_d[RW-1:0]];
  end

  // the processed triangle
  sse_pkg::vtx_t t0_q, t1_q, t2_q;
  logic [31:0]   tl0_q, tl1_q, tl2_q;
  logic [TW-1:0] scan_q, scan_d;
  logic [TW-1:0] nscan_q, nscan_d;
  logic          feed_q, feed_d;
  logic [3:0]    drain_q, drain_d;

  // search row: each probe (one reversed edge) passes three cells per row
  // position; three probes run side by side, one for each processed edge
  sse_pkg::probe_t pin [3];
  sse_pkg::probe_t pmid0 [3];
  sse_pkg::probe_t pmid1 [3];
  sse_pkg::probe_t pout [3];
  sse_pkg::vtx_t   ea [3];
  sse_pkg::vtx_t   eb [3];

  // edge e goes a->b; the search looks for b->a
  assign ea[0] = t2_q; assign eb[0] = t0_q;
  assign ea[1] = t0_q; assign eb[1] = t1_q;
  assign ea[2] = t1_q; assign eb[2] = t2_q;

  for (genvar e = 0; e < 3; e++) begin : g_row
    assign pin[e] = '{valid: feed_q, found: 1'b0, from_v: eb[e], to_v: ea[e]};
    sse_cell u_c0 (.clk_i, .rst_ni, .en_i(1'b1), .src_i(r2_q), .dst_i(r0_q),
                   .probe_i(pin[e]), .probe_o(pmid0[e]));
    sse_cell u_c1 (.clk_i, .rst_ni, .en_i(1'b1), .src_i(r0_q), .dst_i(r1_q),
                   .probe_i(pmid0[e]), .probe_o(pmid1[e]));
    sse_cell u_c2 (.clk_i, .rst_ni, .en_i(1'b1), .src_i(r1_q), .dst_i(r2_q),
                   .probe_i(pmid1[e]), .probe_o(pout[e]));
  end

  // a row is held on r*_q while sub_q runs from 0 to 2 and the probe enters
  // c0 at 0, so c0, c1 and c2 each compare the same row in turn
  logic [1:0] sub_q, sub_d;

  // found flags
  logic [2:0] found_q, found_d;

  // emission
  logic [2:0]  emit_mask_q, emit_mask_d;
  logic [1:0]  edge_q, edge_d;
  logic [2:0]  vix_q, vix_d;
  logic        plast_q;
  logic        pvalid_q;
  sse_pkg::vtx_t pp;
  logic [31:0] plen;
  logic        use_b, ext;
  logic [31:0] ox, oy, oz;
  logic        is_last;

  always_comb begin
    unique case (edge_q)
      2'd0: begin
        use_b = (vix_q == 3'd1 || vix_q == 3'd2 || vix_q == 3'd4);
        pp    = use_b ? t0_q : t2_q;
        plen  = use_b ? tl0_q : tl2_q;
      end
      2'd1: begin
        use_b = (vix_q == 3'd1 || vix_q == 3'd2 || vix_q == 3'd4);
        pp    = use_b ? t1_q : t0_q;
        plen  = use_b ? tl1_q : tl0_q;
      end
      default: begin
        use_b = (vix_q == 3'd1 || vix_q == 3'd2 || vix_q == 3'd4);
        pp    = use_b ? t2_q : t1_q;
        plen  = use_b ? tl2_q : tl1_q;
      end
    endcase
    ext = (vix_q == 3'd2 || vix_q == 3'd4 || vix_q == 3'd5);
    if (!ext) begin
      plen = 32'd0;
    end
  end

  // last when this is vertex five and no later edge remains
  always_comb begin
    is_last = 1'b0;
    if (vix_q == 3'd5) begin
      unique case (edge_q)
        2'd0:    is_last = !(emit_mask_q[1] || emit_mask_q[2]);
        2'd1:    is_last = !emit_mask_q[2];
        default: is_last = 1'b1;
      endcase
    end
  end

  sse_extrude u_ex (.clk_i, .pos_i(pp.x), .dir_i(dir_x_q), .len_i(plen), .res_o(ox));
  sse_extrude u_ey (.clk_i, .pos_i(pp.y), .dir_i(dir_y_q), .len_i(plen), .res_o(oy));
  sse_extrude u_ez (.clk_i, .pos_i(pp.z), .dir_i(dir_z_q), .len_i(plen), .res_o(oz));

  logic [1:0] next_edge;
  logic [2:0] mask_after;
  always_comb begin
    mask_after = emit_mask_q;
    mask_after[edge_q] = 1'b0;
    next_edge = 2'd0;
    if (mask_after[0]) begin
      next_edge = 2'd0;
    end else if (mask_after[1]) begin
      next_edge = 2'd1;
    end else begin
      next_edge = 2'd2;
    end
  end

  // control
  always_comb begin
    state_d     = state_q;
    raddr_d     = scan_q;
    scan_d      = scan_q;
    nscan_d     = nscan_q;
    drain_d     = drain_q;
    sub_d       = sub_q;
    found_d     = found_q;
    emit_mask_d = emit_mask_q;
    edge_d      = edge_q;
    vix_d       = vix_q;
    for (int e = 0; e < 3; e++) begin
      if (pout[e].valid && pout[e].found) begin
        found_d[e] = 1'b1;
      end
    end
    unique case (state_q)
      StIdle: begin
        raddr_d = next_q;
        if (accept && req_i.operation == sse_pkg::OpProcess && next_q < tris) begin
          state_d = StFetch;
          nscan_d = tris;
        end
      end
      StFetch: begin
        raddr_d = '0;
        scan_d  = '0;
        found_d = '0;
        sub_d   = '0;
        state_d = StScan;
      end
      StScan: begin
        // present a row while sub_q steps from 0 to 2; the probe passes one cell each step
        raddr_d = scan_q;
        if (sub_q == 2'd2) begin
          sub_d  = '0;
          scan_d = scan_q + TW'(1);
          raddr_d = scan_q + TW'(1);
          if (scan_q + TW'(1) >= nscan_q) begin
            state_d = StDrain;
            drain_d = 4'd6;
          end
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end
      StDrain: begin
        if (drain_q == 4'd0) begin
          for (int e = 0; e < 3; e++) begin
            emit_mask_d[e] = !found_d[e]
              && !(((e == 0) ? (tl2_q < min_len_q && tl0_q < min_len_q) :
                    (e == 1) ? (tl0_q < min_len_q && tl1_q < min_len_q) :
                               (tl1_q < min_len_q && tl2_q < min_len_q)));
          end
          vix_d = '0;
          if (emit_mask_d == 3'b000) begin
            state_d = StIdle;
          end else begin
            state_d = StEmit;
            edge_d  = emit_mask_d[0] ? 2'd0 : (emit_mask_d[1] ? 2'd1 : 2'd2);
          end
        end else begin
          drain_d = drain_q - 4'd1;
        end
      end
      StEmit: begin
        if (vix_q == 3'd5) begin
          vix_d       = '0;
          emit_mask_d = mask_after;
          edge_d      = next_edge;
          if (mask_after == 3'b000) begin
            state_d = StWait;
            drain_d = 4'd2;
          end
        end else begin
          vix_d = vix_q + 3'd1;
        end
      end
      StWait: begin
        if (drain_q == 4'd0) begin
          state_d = StIdle;
        end else begin
          drain_d = drain_q - 4'd1;
        end
      end
      default: state_d = StIdle;
    endcase
    // probe enters on the first cycle a row is presented
    feed_d = (state_d == StScan) && (sub_d == 2'd0);
  end

  // cells compare against r*_q, which changes in the cycle after raddr; the
  // probe enters while the row is held steady
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      next_q      <= '0;
      scan_q      <= '0;
      nscan_q     <= '0;
      feed_q      <= 1'b0;
      drain_q     <= '0;
      sub_q       <= '0;
      found_q     <= '0;
      emit_mask_q <= '0;
      edge_q      <= '0;
      vix_q       <= '0;
      pvalid_q    <= 1'b0;
      plast_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      nscan_q     <= nscan_d;
      feed_q      <= feed_d;
      drain_q     <= drain_d;
      sub_q       <= sub_d;
      found_q     <= found_d;
      emit_mask_q <= emit_mask_d;
      edge_q      <= edge_d;
      vix_q       <= vix_d;
      pvalid_q    <= state_q == StEmit;
      plast_q     <= is_last;
      if (do_load) begin
        count_q <= count_q + AW'(1);
        if (col_q == 2'd2) begin
          col_q <= 2'd0;
          row_q <= row_q + TW'(1);
        end else begin
          col_q <= col_q + 2'd1;
        end
      end
      if (accept && req_i.operation == sse_pkg::OpClear) begin
        count_q <= '0;
        row_q   <= '0;
        col_q   <= '0;
        next_q  <= '0;
      end
      if (state_q == StFetch) begin
        next_q <= next_q + TW'(1);
      end
    end
  end

  // latch the processed triangle from the read in the fetch cycle
  always_ff @(posedge clk_i) begin
    if (state_q == StFetch) begin
      t0_q <= r0_q; t1_q <= r1_q; t2_q <= r2_q;
      tl0_q <= rl0_q; tl1_q <= rl1_q; tl2_q <= rl2_q;
    end
  end

  assign busy_o      = state_q != StIdle;
  assign res_valid_o = pvalid_q;
  assign res_o       = '{out_x: ox, out_y: oy, out_z: oz, last: plast_q};

  // checks
  a_last_only_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.last |-> res_valid_o) else $error("last without result");
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= AW'(Depth)) else $error("store overfilled");
  a_emit_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |=> res_valid_o) else $error("result lost");
  a_idle_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle && $past(state_q) == StIdle && $past(state_q, 2) == StIdle
    |-> !res_valid_o) else $error("result while idle");

endmodule

@@ design/sse_cell.sv @@
// ----------------------------------------------------------------------------
// sse_cell: one cell of the edge search row
// Compares a passing edge against one stored triangle edge and hands it on.
// ----------------------------------------------------------------------------
module sse_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  sse_pkg::vtx_t   src_i,
  input  sse_pkg::vtx_t   dst_i,
  input  sse_pkg::probe_t probe_i,
  output sse_pkg::probe_t probe_o
);

  sse_pkg::probe_t probe_q, probe_d;

  // match on exact bits of both endpoints
  always_comb begin
    probe_d = probe_i;
    if (en_i && probe_i.valid && src_i == probe_i.from_v && dst_i == probe_i.to_v) begin
      probe_d.found = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule

@@ design/sse_extrude.sv @@
// ----------------------------------------------------------------------------
// sse_extrude: two-stage extrusion of one coordinate
// Multiplies direction by length, rounds to Q16.16, adds and saturates.
// ----------------------------------------------------------------------------
module sse_extrude (
  input  logic        clk_i,
  input  logic [31:0] pos_i,
  input  logic [15:0] dir_i,
  input  logic [31:0] len_i,
  output logic [31:0] res_o
);

  logic [15:0] mag;
  logic        neg_q;
  logic [31:0] pos_q;
  logic [47:0] prod_q;
  logic [34:0] off;
  logic signed [35:0] sum;

  assign mag = dir_i[15] ? (16'd0 - dir_i) : dir_i;

  // stage one: magnitude product
  always_ff @(posedge clk_i) begin
    prod_q <= 48'(mag) * 48'(len_i);
    neg_q  <= dir_i[15];
    pos_q  <= pos_i;
  end

  // stage two: round, add, saturate
  always_comb begin
    off = 35'((prod_q + 48'd8192) >> 14);
    if (neg_q) begin
      sum = 36'(signed'(pos_q)) - signed'({1'b0, off});
    end else begin
      sum = 36'(signed'(pos_q)) + signed'({1'b0, off});
    end
    if (sum > 36'sd2147483647) begin
      res_o = 32'h7fffffff;
    end else if (sum < -36'sd2147483648) begin
      res_o = 32'h80000000;
    end else begin
      res_o = sum[31:0];
    end
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the silhouette edge extruder
// Loads small triangle meshes, processes them and checks every extruded quad
// vertex against an in-bench prediction. Several light directions and
// minimum lengths are set, including the extremes. The sender idles at
// different rates between phases.
// ----------------------------------------------------------------------------
module tb_top;

  // small store so that the full-store case is reached quickly
  localparam int NumTris     = 4;
  localparam int VtxCap      = 3 * NumTris;
  localparam int WatchLimit  = 4000;
  localparam int SettleCyc   = 60;
  localparam logic [1:0] OpUnused = 2'd3;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  sse_pkg::req_t  req_i;
  logic           busy_o;
  logic           cfg_valid_i;
  sse_pkg::cfg_t  cfg_i;
  logic           cfg_ready_o;
  logic           res_valid_o;
  sse_pkg::res_t  res_o;

  shadow_silhouette_edge_extruder_top #(
    .MAX_TRIANGLES(NumTris)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_i      (cfg_i),
    .cfg_ready_o(cfg_ready_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // shadow copy of the configuration and the vertex store
  logic [15:0] dir_x, dir_y, dir_z;
  logic [31:0] min_len;
  logic [31:0] st_x [VtxCap];
  logic [31:0] st_y [VtxCap];
  logic [31:0] st_z [VtxCap];
  logic [31:0] st_len [VtxCap];
  int          vtx_count;
  int          tri_next;

  sse_pkg::req_t pending_reqs[$];
  sse_pkg::res_t quad_vertices_due[$];

  int  idle_pct;
  int  mismatches;
  int  n_reqs, n_results, n_cfg_writes;
  int  quiet_cycles;
  bit  req_taken;

  // ---------------------------------------------------------------- predictor
  function automatic logic [31:0] extrude_coord(logic [31:0] pos, logic [15:0] dir,
                                                logic [31:0] len);
    longint d;
    longint unsigned mag;
    longint off;
    longint sum;
    d = longint'($signed(dir));
    mag = longint'(d < 0 ? -d : d) * longint'({32'd0, len});
    off = longint'((mag + 64'd8192) >> 14);
    if (d < 0) off = -off;
    sum = longint'($signed(pos)) + off;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  function automatic bit same_pos(int a, int b);
    return st_x[a] == st_x[b] && st_y[a] == st_y[b] && st_z[a] == st_z[b];
  endfunction

  // does any complete stored triangle hold the directed edge a->b
  function automatic bit has_edge(int a, int b);
    int s, d;
    for (int t = 0; t < vtx_count / 3; t++) begin
      for (int e = 0; e < 3; e++) begin
        s = t * 3 + (e + 2) % 3;
        d = t * 3 + e;
        if (same_pos(s, a) && same_pos(d, b)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void push_vertex(int idx, bit ext);
    sse_pkg::res_t r;
    logic [31:0] len;
    len = ext ? st_len[idx] : 32'd0;
    r.out_x = extrude_coord(st_x[idx], dir_x, len);
    r.out_y = extrude_coord(st_y[idx], dir_y, len);
    r.out_z = extrude_coord(st_z[idx], dir_z, len);
    r.last  = 1'b0;
    quad_vertices_due.push_back(r);
  endfunction

  function automatic void predict_silhouette(sse_pkg::req_t rq);
    int base, a, b, n;
    int from_v[3];
    int to_v[3];
    sse_pkg::res_t tail;
    from_v = '{2, 0, 1};
    to_v   = '{0, 1, 2};
    n = 0;
    case (rq.operation)
      sse_pkg::OpLoad: begin
        if (vtx_count < VtxCap) begin
          st_x[vtx_count]   = rq.pos_x;
          st_y[vtx_count]   = rq.pos_y;
          st_z[vtx_count]   = rq.pos_z;
          st_len[vtx_count] = rq.extrude_length;
          vtx_count++;
        end
      end
      sse_pkg::OpClear: begin
        vtx_count = 0;
        tri_next  = 0;
      end
      sse_pkg::OpProcess: begin
        base = tri_next * 3;
        if (base + 3 <= vtx_count) begin
          tri_next++;
          for (int e = 0; e < 3; e++) begin
            a = base + from_v[e];
            b = base + to_v[e];
            if (!has_edge(b, a) && (st_len[a] >= min_len || st_len[b] >= min_len)) begin
              push_vertex(a, 1'b0);
              push_vertex(b, 1'b0);
              push_vertex(b, 1'b1);
              push_vertex(a, 1'b0);
              push_vertex(b, 1'b1);
              push_vertex(a, 1'b1);
              n += 6;
            end
          end
          if (n > 0) begin
            tail = quad_vertices_due.pop_back();
            tail.last = 1'b1;
            quad_vertices_due.push_back(tail);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- driver
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || req_taken)) begin
      req_taken = 1'b0;
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        req_i   <= pending_reqs[0];
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      // accepted request
      if (start_i && !busy_o) begin
        predict_silhouette(req_i);
        void'(pending_reqs.pop_front());
        req_taken = 1'b1;
        n_reqs++;
        quiet_cycles = 0;
      end
      if (cfg_valid_i && cfg_ready_o) quiet_cycles = 0;
      // result strobe
      if (res_valid_o) begin
        quiet_cycles = 0;
        n_results++;
        if (quad_vertices_due.size() == 0) begin
          $error("unexpected result x=%h y=%h z=%h last=%b",
                 res_o.out_x, res_o.out_y, res_o.out_z, res_o.last);
          mismatches++;
        end else begin
          sse_pkg::res_t exp_r;
          exp_r = quad_vertices_due.pop_front();
          if (res_o.out_x !== exp_r.out_x) begin
            $error("out_x expected %h actual %h", exp_r.out_x, res_o.out_x);
            mismatches++;
          end
          if (res_o.out_y !== exp_r.out_y) begin
            $error("out_y expected %h actual %h", exp_r.out_y, res_o.out_y);
            mismatches++;
          end
          if (res_o.out_z !== exp_r.out_z) begin
            $error("out_z expected %h actual %h", exp_r.out_z, res_o.out_z);
            mismatches++;
          end
          if (res_o.last !== exp_r.last) begin
            $error("last expected %b actual %b", exp_r.last, res_o.last);
            mismatches++;
          end
        end
      end
      // watchdog
      if (quiet_cycles >= WatchLimit) begin
        $display("timeout with %0d requests and %0d results outstanding",
                 pending_reqs.size(), quad_vertices_due.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return $urandom_range(8) << 16;
    endcase
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return min_len - 32'd1;
      3:       return min_len;
      4:       return $urandom;
      default: return $urandom_range(4 << 16);
    endcase
  endfunction

  function automatic void queue_op(logic [1:0] op);
    sse_pkg::req_t r;
    r.operation      = op;
    r.pos_x          = $urandom;
    r.pos_y          = $urandom;
    r.pos_z          = $urandom;
    r.extrude_length = $urandom;
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_load(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                     logic [31:0] len);
    sse_pkg::req_t r;
    r.operation      = sse_pkg::OpLoad;
    r.pos_x          = x;
    r.pos_y          = y;
    r.pos_z          = z;
    r.extrude_length = len;
    pending_reqs.push_back(r);
  endfunction

  // one mesh: a clear, triangles drawn from a small shared vertex pool, processes
  function automatic int queue_mesh();
    sse_pkg::vtx_t pool[4];
    int   ntri, nld, count, i0, i1, i2;
    count = 0;
    for (int k = 0; k < 4; k++) begin
      pool[k].x = pick_coord();
      pool[k].y = pick_coord();
      pool[k].z = pick_coord();
    end
    queue_op(sse_pkg::OpClear);
    ntri = $urandom_range(1, NumTris);
    nld  = 3 * ntri;
    // sometimes a trailing partial triangle or loads past the full store
    if ($urandom_range(5) == 0) nld += $urandom_range(1, 2);
    for (int v = 0; v < nld; v++) begin
      if (v % 3 == 0) begin
        i0 = $urandom_range(3);
        i1 = (i0 + $urandom_range(1, 3)) % 4;
        i2 = $urandom_range(3);
        while (i2 == i0 || i2 == i1) i2 = (i2 + 1) % 4;
        if ($urandom_range(9) == 0) i2 = i0;
      end
      case (v % 3)
        0:       queue_load(pool[i0].x, pool[i0].y, pool[i0].z, pick_len());
        1:       queue_load(pool[i1].x, pool[i1].y, pool[i1].z, pick_len());
        default: queue_load(pool[i2].x, pool[i2].y, pool[i2].z, pick_len());
      endcase
      count++;
    end
    for (int p = 0; p < ntri + $urandom_range(1); p++) begin
      if ($urandom_range(7) == 0) begin
        queue_op(OpUnused);
        count++;
      end
      queue_op(sse_pkg::OpProcess);
      count++;
    end
    return count + 1;
  endfunction

  // noise: random operations with random content
  function automatic int queue_noise();
    int n;
    n = $urandom_range(3, 8);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(1)) queue_load($urandom, $urandom, $urandom, $urandom);
      else queue_op(2'($urandom_range(3)));
    end
    return n;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_i       <= '{index: idx, data: val};
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sse_pkg::RegDirX:   dir_x   = val[15:0];
      sse_pkg::RegDirY:   dir_y   = val[15:0];
      sse_pkg::RegDirZ:   dir_z   = val[15:0];
      sse_pkg::RegMinLen: min_len = val;
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_light(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           logic [31:0] lmin);
    write_reg(sse_pkg::RegDirX, {16'd0, x});
    write_reg(sse_pkg::RegDirY, {16'd0, y});
    write_reg(sse_pkg::RegDirZ, {16'd0, z});
    write_reg(sse_pkg::RegMinLen, lmin);
  endtask

  // block drained: nothing queued, nothing owed, then a settling pause
  task automatic drain();
    do @(posedge clk_i);
    while (pending_reqs.size() > 0 || quad_vertices_due.size() > 0 || busy_o);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic random_items(int total);
    int sent;
    sent = 0;
    while (sent < total) begin
      if ($urandom_range(9) == 0) sent += queue_noise();
      else sent += queue_mesh();
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    start_i     = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_i       = '0;
    req_taken   = 1'b0;
    mismatches  = 0;
    n_reqs      = 0;
    n_results   = 0;
    n_cfg_writes = 0;
    quiet_cycles = 0;
    idle_pct    = 10;
    dir_x   = 16'd0;
    dir_y   = 16'hC000;
    dir_z   = 16'd0;
    min_len = 32'd655;
    vtx_count = 0;
    tri_next  = 0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset configuration: extremes, saturation, reversed edges
    queue_op(sse_pkg::OpProcess);
    queue_load(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_load(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'd0);
    queue_load(32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 32'd655);
    queue_op(sse_pkg::OpProcess);
    queue_op(sse_pkg::OpProcess);
    queue_op(OpUnused);
    queue_load(32'h0, 32'h0, 32'h0, 32'd654);
    queue_load(32'h0001_0000, 32'h0, 32'h0, 32'd654);
    queue_op(sse_pkg::OpProcess);
    queue_load(32'h0, 32'h0001_0000, 32'h0, 32'd654);
    queue_load(32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000);
    queue_load(32'h0, 32'h0, 32'h0, 32'h0002_0000);
    queue_load(32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000);
    queue_op(sse_pkg::OpProcess);
    queue_op(sse_pkg::OpProcess);
    for (int k = 0; k < 7; k++) queue_load(pick_coord(), pick_coord(), pick_coord(), pick_len());
    queue_op(sse_pkg::OpClear);
    queue_op(sse_pkg::OpProcess);
    drain();

    // phase one: strongest light extremes, every edge length passes
    set_light(16'd16384, 16'hC000, 16'd16384, 32'd0);
    random_items(40);
    drain();

    // phase two: opposite extremes, only edges with a full-length end pass
    idle_pct = 83;
    set_light(16'hC000, 16'd16384, 16'hC000, 32'hFFFF_FFFF);
    random_items(15);
    drain();
    set_light(16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
              16'($urandom_range(32768) - 16384), 32'($urandom_range(1 << 17)));
    random_items(20);
    drain();

    // phase three: no idling
    idle_pct = 0;
    set_light(16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
              16'($urandom_range(32768) - 16384), 32'd655);
    random_items(35);
    drain();

    $display("covered %0d requests, %0d extruded vertices, %0d register writes",
             n_reqs, n_results, n_cfg_writes);
    $display("light directions at both extremes, minimum length 0 to full scale");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sse_pkg.sv
design/sse_cell.sv
design/sse_extrude.sv
design/shadow_silhouette_edge_extruder_top.sv
test/tb_top.sv
